// ===== rtl/assert_macros.svh =====
// assertion macros used by the top cache unit
// each macro expands to a clocked concurrent assertion, or to nothing under synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define A_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define A_IMPLY(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);
`define A_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define A_ALWAYS(lbl, cond, msg)
`define A_IMPLY(lbl, pre, post, msg)
`define A_NEXT(lbl, pre, post, msg)
`endif
`endif

// ===== rtl/slru_pkg.sv =====
// shared types, command codes and default sizes of the lru cache
// used by the lane, merge and top modules, no dependencies
package slru_pkg;

  localparam int CACHE_BYTES_DEF = 32768;
  localparam int LINE_BYTES_DEF  = 64;
  localparam int WAYS_DEF        = 4;

  // way index and rank fields are sized for up to 16 ways
  localparam int WAY_IDX_W = 4;

  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_INVAL = 2'd2;
  localparam logic [1:0] CMD_FLUSH = 2'd3;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] address;
    logic [63:0] write_data;
    logic [3:0]  byte_count;
  } in_word_t;

  typedef struct packed {
    logic        hit;
    logic [63:0] read_data;
    logic [3:0]  bytes_copied;
    logic [31:0] hit_total;
    logic [31:0] miss_total;
  } out_word_t;

  typedef struct packed {
    logic                 match;
    logic                 valid;
    logic [WAY_IDX_W-1:0] rank;
  } lane_stat_t;

  typedef struct packed {
    logic [1:0]           cmd;
    logic                 hit;
    logic [WAY_IDX_W-1:0] way;
    logic [WAY_IDX_W-1:0] old_rank;
    logic                 touch_valid;
  } lane_ctl_t;

endpackage

// ===== rtl/slru_ram.sv =====
// generic simple dual port ram, one write and one registered read port
// no dependencies
module slru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/slru_lane.sv =====
// one way of a set: tag compare and next state of its metadata
// depends on slru_pkg
module slru_lane #(
  parameter int LANE       = 0,
  parameter int TAG_W      = 19,
  parameter int RANK_W     = 2,
  parameter int LINE_BYTES = 64,
  localparam int MW        = 2 + RANK_W + TAG_W + LINE_BYTES
) (
  input  logic [MW-1:0]         meta_in,
  input  logic [TAG_W-1:0]      tag_in,
  input  logic [LINE_BYTES-1:0] wr_mask,
  input  slru_pkg::lane_ctl_t   ctl,
  output slru_pkg::lane_stat_t  stat,
  output logic [MW-1:0]         meta_out
);

  logic                  valid, dirty;
  logic [RANK_W-1:0]     rank, old_rank, rank_nxt;
  logic [TAG_W-1:0]      tag;
  logic [LINE_BYTES-1:0] mask;
  logic                  valid_nxt, dirty_nxt;
  logic [TAG_W-1:0]      tag_nxt;
  logic [LINE_BYTES-1:0] mask_nxt;
  logic                  is_me;

  assign mask  = meta_in[LINE_BYTES-1:0];
  assign tag   = meta_in[LINE_BYTES +: TAG_W];
  assign rank  = meta_in[LINE_BYTES+TAG_W +: RANK_W];
  assign dirty = meta_in[MW-2];
  assign valid = meta_in[MW-1];

  assign stat.match = valid && (tag == tag_in);
  assign stat.valid = valid;
  assign stat.rank  = slru_pkg::WAY_IDX_W'(rank);

  assign is_me    = (ctl.way == slru_pkg::WAY_IDX_W'(LANE));
  assign old_rank = ctl.old_rank[RANK_W-1:0];

  always_comb begin
    valid_nxt = valid;
    dirty_nxt = dirty;
    rank_nxt  = rank;
    tag_nxt   = tag;
    mask_nxt  = mask;
    case (ctl.cmd)
      slru_pkg::CMD_READ, slru_pkg::CMD_WRITE: begin
        // move the chosen way to most recent
        if (ctl.hit || ctl.cmd == slru_pkg::CMD_WRITE) begin
          if (is_me) begin
            rank_nxt = '0;
          end else if (valid && (!ctl.touch_valid || rank < old_rank)) begin
            rank_nxt = rank + RANK_W'(1);
          end
        end
        if (ctl.cmd == slru_pkg::CMD_WRITE && is_me) begin
          valid_nxt = 1'b1;
          dirty_nxt = 1'b1;
          tag_nxt   = tag_in;
          mask_nxt  = ctl.hit ? (mask | wr_mask) : wr_mask;
        end
      end
      slru_pkg::CMD_INVAL: begin
        if (ctl.hit) begin
          if (is_me) begin
            valid_nxt = 1'b0;
            dirty_nxt = 1'b0;
            rank_nxt  = '0;
          end else if (valid && rank > old_rank) begin
            rank_nxt = rank - RANK_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign meta_out = {valid_nxt, dirty_nxt, rank_nxt, tag_nxt, mask_nxt};

endmodule

// ===== rtl/slru_merge.sv =====
// merges the lane results: hit way, first free way, least recent way
// depends on slru_pkg
module slru_merge #(
  parameter int WAYS = 4
) (
  input  logic [1:0]           cmd,
  input  slru_pkg::lane_stat_t stat [WAYS],
  output slru_pkg::lane_ctl_t  ctl
);

  localparam int WAY_W = WAYS > 1 ? $clog2(WAYS) : 1;

  logic                           hit, found;
  logic [slru_pkg::WAY_IDX_W-1:0] hway, iway, lway, best, way;

  always_comb begin
    hit   = 1'b0;
    found = 1'b0;
    hway  = '0;
    iway  = '0;
    lway  = '0;
    best  = '0;
    for (int i = 0; i < WAYS; i++) begin
      if (stat[i].match && !hit) begin
        hit  = 1'b1;
        hway = slru_pkg::WAY_IDX_W'(i);
      end
      if (!stat[i].valid && !found) begin
        found = 1'b1;
        iway  = slru_pkg::WAY_IDX_W'(i);
      end
      // ties go to the higher way
      if (stat[i].rank >= best) begin
        best = stat[i].rank;
        lway = slru_pkg::WAY_IDX_W'(i);
      end
    end
    hit = hit && (cmd != slru_pkg::CMD_FLUSH);
    way = hit ? hway : (found ? iway : lway);
  end

  assign ctl.cmd         = cmd;
  assign ctl.hit         = hit;
  assign ctl.way         = way;
  assign ctl.old_rank    = stat[way[WAY_W-1:0]].rank;
  assign ctl.touch_valid = hit || !found;

endmodule

// ===== rtl/set_associative_lru_cache_unit.sv =====
// set-associative cache with true lru order and write allocate
// depends on slru_pkg, slru_ram, slru_lane, slru_merge and assert_macros.svh
//
// usage:
// - in_valid/in_stall/in_data carry one request word: read, write,
//   invalidate line or flush all, with address, up to 8 bytes and a count
// - out_valid/out_stall/out_data return one result word per request:
//   hit, read bytes, bytes moved and the saturating hit and miss totals
// - a request is read from the metadata and data rams as it is taken,
//   then the way lanes compare, the merge picks a way and the rams are
//   written; a new request is taken only once the last one is through
// - a flush returns its result and then sweeps the metadata ram one set
//   per cycle, all SETS sets (128 by default), with in_stall high
// - after reset the same sweep runs before the first request is taken
// - a stalled result sits in the output register; one more request is
//   taken and then held until the result is gone
// - line size and set count must be powers of two
`include "assert_macros.svh"
module set_associative_lru_cache_unit #(
  parameter int CACHE_BYTES = slru_pkg::CACHE_BYTES_DEF,
  parameter int LINE_BYTES  = slru_pkg::LINE_BYTES_DEF,
  parameter int WAYS        = slru_pkg::WAYS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  slru_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output slru_pkg::out_word_t out_data
);

  localparam int SETS_Q   = CACHE_BYTES / (LINE_BYTES * WAYS);
  localparam int SETS     = SETS_Q > 0 ? SETS_Q : 1;
  localparam int OFF_W    = $clog2(LINE_BYTES);
  localparam int SET_BITS = $clog2(SETS);
  localparam int SET_W    = SET_BITS > 0 ? SET_BITS : 1;
  localparam int TAG_W    = 32 - OFF_W - SET_BITS;
  localparam int RANK_W   = WAYS > 1 ? $clog2(WAYS) : 1;
  localparam int WAY_W    = RANK_W;
  localparam int MW       = 2 + RANK_W + TAG_W + LINE_BYTES;
  localparam int WPL      = LINE_BYTES / 8;
  localparam int WORD_W   = $clog2(WPL);
  localparam int DDEPTH   = SETS * WPL;
  localparam int DA_W     = $clog2(DDEPTH);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_LOOK = 3'b010,
    S_CLR  = 3'b100
  } state_t;

  state_t              state_r, state_nxt;
  slru_pkg::in_word_t  req_r, req_nxt;
  slru_pkg::out_word_t out_r, out_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [SET_W-1:0]    clr_r, clr_nxt;
  logic [31:0]         hits_r, hits_nxt, miss_r, miss_nxt;

  logic               accept, fin;
  logic [31:0]        src_addr;
  logic [OFF_W-1:0]   src_off, off;
  logic [SET_W-1:0]   src_set, set_idx;
  logic [TAG_W-1:0]   tag;
  logic [1:0]         cmd;
  logic [3:0]         count, copy;
  logic [OFF_W:0]     room;
  logic [LINE_BYTES-1:0] wr_mask, sel_mask;

  logic               meta_we;
  logic [SET_W-1:0]   meta_waddr;
  logic [WAYS*MW-1:0] meta_rd, meta_wd;

  logic [2:0]         bank_i  [8];
  logic [DA_W-1:0]    bank_a  [8];
  logic [7:0]         bank_wd [8];
  logic [7:0]         data_rd [WAYS][8];

  slru_pkg::lane_stat_t stat [WAYS];
  slru_pkg::lane_ctl_t  ctl;
  logic [WAY_W-1:0]     sel;
  logic [63:0]          rdata;

  assign accept = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign fin = (state_r == S_LOOK) && (!out_valid_r || !out_stall);

  // ram read address follows the input while idle, the held request otherwise
  assign src_addr = (state_r == S_IDLE) ? in_data.address : req_r.address;
  assign src_off  = OFF_W'(src_addr);
  assign src_set  = SET_W'((src_addr >> OFF_W) & 32'(SETS - 1));
  assign off      = OFF_W'(req_r.address);
  assign set_idx  = SET_W'((req_r.address >> OFF_W) & 32'(SETS - 1));
  assign tag      = TAG_W'(req_r.address >> (OFF_W + SET_BITS));
  assign cmd      = req_r.cmd;

  // byte count clipped to 8 and to the end of the line
  always_comb begin
    count = (req_r.byte_count > 4'd8) ? 4'd8 : req_r.byte_count;
    room  = (OFF_W + 1)'(LINE_BYTES) - {1'b0, off};
    copy  = ((OFF_W + 1)'(count) < room) ? count : 4'(room);
  end

  always_comb begin
    for (int k = 0; k < LINE_BYTES; k++) begin
      wr_mask[k] = ((OFF_W + 1)'(k) >= {1'b0, off}) &&
                   ((OFF_W + 1)'(k) < {1'b0, off} + (OFF_W + 1)'(copy));
    end
  end

  // byte bank b holds line bytes whose offset mod 8 is b
  always_comb begin
    logic [OFF_W-1:0] k;
    for (int b = 0; b < 8; b++) begin
      bank_i[b]  = 3'(b) - src_off[2:0];
      k          = src_off + OFF_W'(bank_i[b]);
      bank_a[b]  = DA_W'({src_set, WORD_W'(k >> 3)});
      bank_wd[b] = req_r.write_data[8*bank_i[b] +: 8];
    end
  end

  slru_ram #(.WIDTH(WAYS * MW), .DEPTH(SETS)) u_meta (
    .clk   (clk),
    .we    (meta_we),
    .waddr (meta_waddr),
    .wdata (meta_wd),
    .raddr (src_set),
    .rdata (meta_rd)
  );

  for (genvar w = 0; w < WAYS; w++) begin : g_way
    logic [MW-1:0] meta_out;

    slru_lane #(.LANE(w), .TAG_W(TAG_W), .RANK_W(RANK_W), .LINE_BYTES(LINE_BYTES)) u_lane (
      .meta_in  (meta_rd[w*MW +: MW]),
      .tag_in   (tag),
      .wr_mask  (wr_mask),
      .ctl      (ctl),
      .stat     (stat[w]),
      .meta_out (meta_out)
    );

    assign meta_wd[w*MW +: MW] = (state_r == S_CLR) ? '0 : meta_out;

    for (genvar b = 0; b < 8; b++) begin : g_bank
      logic we;
      assign we = fin && (cmd == slru_pkg::CMD_WRITE) && (sel == WAY_W'(w)) &&
                  ({1'b0, bank_i[b]} < copy);
      slru_ram #(.WIDTH(8), .DEPTH(DDEPTH)) u_data (
        .clk   (clk),
        .we    (we),
        .waddr (bank_a[b]),
        .wdata (bank_wd[b]),
        .raddr (bank_a[b]),
        .rdata (data_rd[w][b])
      );
    end
  end

  slru_merge #(.WAYS(WAYS)) u_merge (
    .cmd  (cmd),
    .stat (stat),
    .ctl  (ctl)
  );

  assign sel = ctl.way[WAY_W-1:0];
  assign sel_mask = meta_rd[32'(sel) * MW +: LINE_BYTES];

  // unwritten bytes of a line read as zero
  always_comb begin
    logic [OFF_W-1:0] k;
    for (int i = 0; i < 8; i++) begin
      k = off + OFF_W'(i);
      rdata[8*i +: 8] = (4'(i) < copy && sel_mask[k]) ?
                        data_rd[sel][3'(off[2:0] + 3'(i))] : 8'd0;
    end
  end

  assign meta_we    = (state_r == S_CLR) || (fin && cmd != slru_pkg::CMD_FLUSH);
  assign meta_waddr = (state_r == S_CLR) ? clr_r : set_idx;

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    clr_nxt       = clr_r;
    hits_nxt      = hits_r;
    miss_nxt      = miss_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          req_nxt   = in_data;
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        if (fin) begin
          if (cmd == slru_pkg::CMD_READ || cmd == slru_pkg::CMD_WRITE) begin
            if (ctl.hit) begin
              hits_nxt = (hits_r == '1) ? hits_r : hits_r + 32'd1;
            end else begin
              miss_nxt = (miss_r == '1) ? miss_r : miss_r + 32'd1;
            end
          end
          out_nxt.hit          = ctl.hit;
          out_nxt.read_data    = (cmd == slru_pkg::CMD_READ && ctl.hit) ? rdata : 64'd0;
          out_nxt.bytes_copied = ((cmd == slru_pkg::CMD_READ && ctl.hit) ||
                                  cmd == slru_pkg::CMD_WRITE) ? copy : 4'd0;
          out_nxt.hit_total    = hits_nxt;
          out_nxt.miss_total   = miss_nxt;
          out_valid_nxt        = 1'b1;
          clr_nxt              = '0;
          state_nxt            = (cmd == slru_pkg::CMD_FLUSH) ? S_CLR : S_IDLE;
        end
      end
      S_CLR: begin
        clr_nxt = clr_r + SET_W'(1);
        if (clr_r == SET_W'(SETS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      out_valid_r <= 1'b0;
      clr_r       <= '0;
      hits_r      <= '0;
      miss_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      clr_r       <= clr_nxt;
      hits_r      <= hits_nxt;
      miss_r      <= miss_nxt;
    end
    req_r <= req_nxt;
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  logic [WAYS-1:0] match_vec;
  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      match_vec[i] = stat[i].match;
    end
  end

  `A_NEXT(a_accept_look, accept, state_r == S_LOOK, "accepted word did not start lookup")
  `A_IMPLY(a_one_match, state_r == S_LOOK, $onehot0(match_vec), "tag matched in two ways")
  `A_IMPLY(a_count_up, $past(rst_n), hits_r >= $past(hits_r) && miss_r >= $past(miss_r),
           "hit or miss total went down")

endmodule
